>>> rtl/core/delimited_value_extractor_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the delimited value extractor
// Concurrent checks sampled on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef DELIMITED_VALUE_EXTRACTOR_CORE_ASSERT_SVH
`define DELIMITED_VALUE_EXTRACTOR_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// A condition that holds at every clock edge out of reset.
`define DVE_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("dve assertion failed");
// A trigger that must be followed by a condition in the next cycle.
`define DVE_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("dve assertion failed");
`else
`define DVE_ASSERT(label, cond)
`define DVE_ASSERT_NEXT(label, trig, cond)
`endif

`endif

>>> rtl/core/dve_pkg.sv
// ---------------------------------------------------------------------------
// dve_pkg
// Shared types and constants of the delimited value extractor.
// ---------------------------------------------------------------------------
package dve_pkg;

    // String offsets run from 0 to MAX_LEN inclusive.
    localparam int MAX_LEN     = 65536;
    localparam int POS_W       = 17;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int CMD_DEPTH   = 4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LOW  = 2'd0,
        REG_PATTERN_HIGH = 2'd1,
        REG_PATTERN_LEN  = 2'd2,
        REG_END_CHAR     = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic             value_valid;
        logic [POS_W-1:0] value_start;
        logic [POS_W-1:0] value_length;
        logic             overflow;
        logic             last_result;
    } result_t;

    typedef struct packed {
        logic                  en;
        reg_index_t            index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_write_t;

    // One classified byte handed from the front end to the back end.
    typedef struct packed {
        logic [POS_W-1:0] pos;      // offset of this byte
        logic             scanned;  // byte lay below the length limit
        logic             end_hit;  // byte is the end character
        logic             open;     // a value opens after this byte
        logic             last;     // byte ends the string
        logic             ovf;      // overflow flag including this byte
    } cmd_t;

endpackage

>>> rtl/core/delimited_value_extractor_core.sv
// ---------------------------------------------------------------------------
// delimited_value_extractor_core
// Scans strings byte by byte for a start pattern and reports each value after
// it, up to the next end character or string end, as an offset and a length.
// ---------------------------------------------------------------------------
//
//   Channel   Handshake          Payload     Direction
//   input     push / full        item        one byte of a string in
//   result    empty / pop        result      one extracted value or marker out
//   config    wr_en              wr_index,   register write, no wait
//                                wr_data
//
// The front end takes one byte per cycle while the queue is not full and
// settles pattern matching and the open-value count in the accepting cycle.
// The back end takes commands in order, emits a result for each value an end
// character closes, and at the end of a string flushes open values, or gives
// a bare end marker if the last byte yields none. A four-entry command queue
// absorbs short bursts, after which full holds the input. A result sits in
// the output register until popped; while it waits the back end stalls at its
// next result, but the front end keeps accepting until the queue fills. Reset
// clears all control state at once; no clearing pass is needed.
// ---------------------------------------------------------------------------
module delimited_value_extractor_core
    import dve_pkg::*;
#(
    parameter int MAX_PATTERN = 16,
    parameter int MAX_OPEN    = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  item_t                  item,
    output logic                   empty,
    input  logic                   pop,
    output result_t                result,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data
);

    cfg_write_t cfg;
    logic       cmd_push;
    cmd_t       push_cmd;
    logic       cmd_valid;
    cmd_t       head_cmd;
    logic       cmd_pop;

    // The configuration port is gathered into one write word for the front.
    assign cfg.en    = wr_en;
    assign cfg.index = reg_index_t'(wr_index);
    assign cfg.data  = wr_data;

    // Front end: registers, pattern match, open-value bookkeeping and the
    // overflow flag. It classifies each byte into one command.
    dve_front #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_OPEN    (MAX_OPEN)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .push     (push),
        .full     (full),
        .item     (item),
        .cmd_push (cmd_push),
        .cmd      (push_cmd)
    );

    // Commands wait here so that a burst of closing values on one byte does
    // not stall the input at once.
    dve_cmd_queue u_cmd_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (cmd_pop),
        .valid    (cmd_valid),
        .head_cmd (head_cmd)
    );

    // Back end: the store of open value starts, closing and end-of-string
    // flushing, one result word per cycle, when the output register is free.
    dve_back #(
        .MAX_OPEN (MAX_OPEN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (head_cmd),
        .cmd_pop   (cmd_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule

>>> rtl/core/dve_front.sv
// ---------------------------------------------------------------------------
// dve_front
// Holds the configuration, matches the start pattern and tracks how many
// values are open, producing one command per accepted byte.
// ---------------------------------------------------------------------------
`include "delimited_value_extractor_core_assert.svh"

module dve_front
    import dve_pkg::*;
#(
    parameter int MAX_PATTERN = 16,
    parameter int MAX_OPEN    = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_write_t cfg,
    input  logic       push,
    input  logic       full,
    input  item_t      item,
    output logic       cmd_push,
    output cmd_t       cmd
);

    localparam int PLEN_W = $clog2(MAX_PATTERN + 1);
    localparam int PIDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int CNT_W  = $clog2(MAX_OPEN + 1);

    logic [63:0]       pat_low_reg;
    logic [63:0]       pat_high_reg;
    logic [4:0]        pat_len_reg;
    logic [7:0]        end_char_reg;
    logic [7:0]        window_reg [MAX_PATTERN];
    logic [PLEN_W-1:0] since_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              recent_reg;
    logic              ovf_reg;

    logic [7:0]        window_next [MAX_PATTERN];
    logic [PLEN_W-1:0] since_next;
    logic [PLEN_W-1:0] plen;
    logic [127:0]      pat_all;
    logic              win_eq;
    logic              accept;
    logic              scanned;
    logic              end_hit;
    logic              match;
    logic              open_new;
    logic              ovf_next;
    logic [CNT_W-1:0]  count_mid;

    assign accept  = push && !full;
    assign pat_all = {pat_high_reg, pat_low_reg};
    assign scanned = (pos_reg < POS_W'(MAX_LEN));
    assign end_hit = scanned && (item.data_byte == end_char_reg);

    // A zero length acts as one byte, an oversized one as the full window.
    always_comb
    begin
        if (pat_len_reg == 5'd0)
        begin
            plen = PLEN_W'(1);
        end
        else if (32'(pat_len_reg) > MAX_PATTERN)
        begin
            plen = PLEN_W'(MAX_PATTERN);
        end
        else
        begin
            plen = PLEN_W'(pat_len_reg);
        end
    end

    always_comb
    begin
        window_next[0] = item.data_byte;
        for (int k = 1; k < MAX_PATTERN; k++)
        begin
            window_next[k] = window_reg[k-1];
        end
    end

    // Pattern byte 0 lines up with the oldest of the last plen bytes.
    always_comb
    begin
        logic [PLEN_W-1:0] widx;
        win_eq = 1'b1;
        widx   = '0;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (PLEN_W'(i) < plen)
            begin
                widx = plen - PLEN_W'(i) - PLEN_W'(1);
                if (window_next[widx[PIDX_W-1:0]] != pat_all[8*i +: 8])
                begin
                    win_eq = 1'b0;
                end
            end
        end
    end

    assign since_next = (since_reg < PLEN_W'(MAX_PATTERN)) ? since_reg + PLEN_W'(1)
                                                            : since_reg;
    assign match      = scanned && (since_next >= plen) && win_eq;

    // On an end character every open value closes except one opened by the
    // previous byte, which starts at this very byte.
    assign count_mid = end_hit ? (recent_reg ? CNT_W'(1) : '0) : count_reg;
    assign open_new  = match && (count_mid < CNT_W'(MAX_OPEN));
    assign ovf_next  = ovf_reg || !scanned || (match && !open_new);

    assign cmd_push    = accept;
    assign cmd.pos     = pos_reg;
    assign cmd.scanned = scanned;
    assign cmd.end_hit = end_hit;
    assign cmd.open    = open_new;
    assign cmd.last    = item.last_byte;
    assign cmd.ovf     = ovf_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= 5'd1;
            end_char_reg <= '0;
        end
        else if (cfg.en)
        begin
            case (cfg.index)
                REG_PATTERN_LOW:  pat_low_reg  <= cfg.data;
                REG_PATTERN_HIGH: pat_high_reg <= cfg.data;
                REG_PATTERN_LEN:  pat_len_reg  <= cfg.data[4:0];
                REG_END_CHAR:     end_char_reg <= cfg.data[7:0];
                default:          pat_low_reg  <= pat_low_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            since_reg  <= '0;
            pos_reg    <= '0;
            count_reg  <= '0;
            recent_reg <= 1'b0;
            ovf_reg    <= 1'b0;
        end
        else if (accept)
        begin
            if (item.last_byte)
            begin
                since_reg  <= '0;
                pos_reg    <= '0;
                count_reg  <= '0;
                recent_reg <= 1'b0;
                ovf_reg    <= 1'b0;
            end
            else if (scanned)
            begin
                since_reg  <= match ? '0 : since_next;
                pos_reg    <= pos_reg + POS_W'(1);
                count_reg  <= count_mid + CNT_W'(open_new);
                recent_reg <= open_new;
                ovf_reg    <= ovf_next;
            end
            else
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // Only bytes that are scanned move the window; the byte count guards
    // against bytes of an earlier string taking part in a match.
    always_ff @(posedge clk)
    begin
        if (accept && scanned)
        begin
            for (int k = 0; k < MAX_PATTERN; k++)
            begin
                window_reg[k] <= window_next[k];
            end
        end
    end

    `DVE_ASSERT(a_front_count_bound, count_reg <= CNT_W'(MAX_OPEN))
    `DVE_ASSERT(a_front_recent_has_open, !recent_reg || (count_reg != '0))
    `DVE_ASSERT_NEXT(a_front_string_clears, accept && item.last_byte,
        (pos_reg == '0) && (count_reg == '0) && !ovf_reg)

endmodule

>>> rtl/core/dve_cmd_queue.sv
// ---------------------------------------------------------------------------
// dve_cmd_queue
// Small first-in first-out queue of commands between front and back end.
// ---------------------------------------------------------------------------
module dve_cmd_queue
    import dve_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic valid,
    output cmd_t head_cmd
);

    localparam int PTR_W = $clog2(CMD_DEPTH);
    localparam int CNT_W = $clog2(CMD_DEPTH + 1);

    cmd_t             slots_reg [CMD_DEPTH];
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(CMD_DEPTH));
    assign valid    = (count_reg != '0);
    assign head_cmd = slots_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> rtl/core/dve_back.sv
// ---------------------------------------------------------------------------
// dve_back
// Keeps the open value starts, closes and flushes them one result per cycle
// while the output is free, and holds the result register toward the output.
// ---------------------------------------------------------------------------
`include "delimited_value_extractor_core_assert.svh"

module dve_back
    import dve_pkg::*;
#(
    parameter int MAX_OPEN = 8
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    input  cmd_t    cmd,
    output logic    cmd_pop,
    input  logic    pop,
    output logic    empty,
    output result_t result
);

    localparam int IDX_W = (MAX_OPEN > 1) ? $clog2(MAX_OPEN) : 1;
    localparam int CNT_W = $clog2(MAX_OPEN + 1);

    typedef enum logic [1:0] {
        ST_CLOSE = 2'b01,
        ST_FLUSH = 2'b10
    } back_state_t;

    back_state_t      state_reg;
    back_state_t      state_next;
    logic [POS_W-1:0] starts_reg [MAX_OPEN];
    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] tail_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             emitted_reg;
    logic             emitted_next;
    result_t          out_reg;
    logic             out_valid_reg;

    logic [POS_W-1:0] head_start;
    logic [POS_W-1:0] end_pos;
    logic             slot_free;
    logic             close_hit;
    logic             emit;
    result_t          emit_res;
    logic             entry_pop;
    logic             entry_push;

    assign head_start = starts_reg[head_reg];
    assign end_pos    = cmd.pos + POS_W'(cmd.scanned);
    assign slot_free  = !out_valid_reg || pop;
    assign close_hit  = cmd.end_hit && (cnt_reg != '0) && (head_start < cmd.pos);

    always_comb
    begin
        state_next   = state_reg;
        emitted_next = emitted_reg;
        emit         = 1'b0;
        emit_res     = '0;
        entry_pop    = 1'b0;
        entry_push   = 1'b0;
        cmd_pop      = 1'b0;
        case (state_reg)
            ST_CLOSE:
            begin
                if (cmd_valid)
                begin
                    if (close_hit)
                    begin
                        if (slot_free)
                        begin
                            emit                  = 1'b1;
                            emit_res.value_valid  = 1'b1;
                            emit_res.value_start  = head_start;
                            emit_res.value_length = cmd.pos - head_start;
                            emit_res.overflow     = cmd.ovf;
                            emit_res.last_result  = cmd.last && !cmd.open &&
                                                    (cnt_reg == CNT_W'(1));
                            entry_pop             = 1'b1;
                            emitted_next          = 1'b1;
                        end
                    end
                    else
                    begin
                        entry_push = cmd.open;
                        if (cmd.last)
                        begin
                            state_next = ST_FLUSH;
                        end
                        else
                        begin
                            cmd_pop      = 1'b1;
                            emitted_next = 1'b0;
                        end
                    end
                end
            end
            ST_FLUSH:
            begin
                if (cnt_reg != '0)
                begin
                    if (slot_free)
                    begin
                        emit                  = 1'b1;
                        emit_res.value_valid  = 1'b1;
                        emit_res.value_start  = head_start;
                        emit_res.value_length = end_pos - head_start;
                        emit_res.overflow     = cmd.ovf;
                        emit_res.last_result  = (cnt_reg == CNT_W'(1));
                        entry_pop             = 1'b1;
                        emitted_next          = 1'b1;
                    end
                end
                else if (emitted_reg || slot_free)
                begin
                    // A string whose last byte yields no value still gets
                    // a bare end marker.
                    if (!emitted_reg)
                    begin
                        emit                 = 1'b1;
                        emit_res.overflow    = cmd.ovf;
                        emit_res.last_result = 1'b1;
                    end
                    cmd_pop      = 1'b1;
                    emitted_next = 1'b0;
                    state_next   = ST_CLOSE;
                end
            end
            default:
            begin
                state_next = ST_CLOSE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLOSE;
            head_reg      <= '0;
            tail_reg      <= '0;
            cnt_reg       <= '0;
            emitted_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            emitted_reg <= emitted_next;
            if (entry_pop)
            begin
                head_reg <= (head_reg == IDX_W'(MAX_OPEN - 1)) ? '0 : head_reg + IDX_W'(1);
            end
            if (entry_push)
            begin
                tail_reg <= (tail_reg == IDX_W'(MAX_OPEN - 1)) ? '0 : tail_reg + IDX_W'(1);
            end
            cnt_reg <= cnt_reg + CNT_W'(entry_push) - CNT_W'(entry_pop);
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (entry_push)
        begin
            starts_reg[tail_reg] <= cmd.pos + POS_W'(1);
        end
        if (emit)
        begin
            out_reg <= emit_res;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    `DVE_ASSERT(a_back_count_bound, cnt_reg <= CNT_W'(MAX_OPEN))
    `DVE_ASSERT(a_back_flush_has_cmd, (state_reg != ST_FLUSH) || (cmd_valid && cmd.last))
    `DVE_ASSERT_NEXT(a_back_last_drains, emit && emit_res.last_result, cnt_reg == '0)

endmodule

>>> verif/extractor_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// Delimited value extractor scoreboard
// Predicts the value words of the extractor for every byte the block
// accepts and checks each popped word against the oldest prediction.
// ----------------------------------------------------------------------------
package extractor_scoreboard_pkg;

    import dve_pkg::*;

    localparam int PATTERN_SLOTS = 16;
    localparam int OPEN_SLOTS    = 8;

    class extractor_scoreboard;

        logic [63:0] pattern_low;
        logic [63:0] pattern_high;
        logic [4:0]  pattern_len;
        logic [7:0]  end_char;

        logic [7:0]  recent [PATTERN_SLOTS];
        int          since_match;
        int          next_pos;
        int          open_starts [$];
        bit          overflow_seen;

        result_t     pending_values [$];
        int          error_count;

        function new();
            pattern_low  = '0;
            pattern_high = '0;
            pattern_len  = 5'd1;
            end_char     = '0;
            error_count  = 0;
            clear_string();
        endfunction

        function void clear_string();
            foreach (recent[i])
                recent[i] = '0;
            since_match   = 0;
            next_pos      = 0;
            overflow_seen = 1'b0;
            open_starts.delete();
        endfunction

        function void write_reg(reg_index_t index, logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_PATTERN_LOW:  pattern_low  = data;
                REG_PATTERN_HIGH: pattern_high = data;
                REG_PATTERN_LEN:  pattern_len  = data[4:0];
                REG_END_CHAR:     end_char     = data[7:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] pattern_byte(int i);
            if (i < 8)
                return pattern_low[i*8 +: 8];
            return pattern_high[(i-8)*8 +: 8];
        endfunction

        // The newest byte sits in slot 0, so pattern byte i lines up with
        // slot len-1-i.
        function bit window_matches(int len);
            for (int i = 0; i < len; i++)
                if (recent[len-1-i] != pattern_byte(i))
                    return 1'b0;
            return 1'b1;
        endfunction

        function result_t make_value(bit valid, int start, int len);
            result_t r;
            r              = '0;
            r.value_valid  = valid;
            r.value_start  = start[POS_W-1:0];
            r.value_length = len[POS_W-1:0];
            return r;
        endfunction

        function void accept_byte(item_t word);
            result_t found [$];
            int      plen;
            int      pos;
            bit      ovf;

            if (next_pos >= MAX_LEN) begin
                overflow_seen = 1'b1;
            end
            else begin
                pos  = next_pos;
                plen = int'(pattern_len);
                if (plen < 1)
                    plen = 1;
                if (plen > PATTERN_SLOTS)
                    plen = PATTERN_SLOTS;

                // Values close before the byte itself is matched.
                if (word.data_byte == end_char)
                    while (open_starts.size() > 0 && open_starts[0] < pos) begin
                        found = {found, make_value(1'b1, open_starts[0],
                                                   pos - open_starts[0])};
                        void'(open_starts.pop_front());
                    end

                for (int i = PATTERN_SLOTS - 1; i > 0; i--)
                    recent[i] = recent[i-1];
                recent[0] = word.data_byte;
                if (since_match < PATTERN_SLOTS)
                    since_match++;

                if (since_match >= plen && window_matches(plen)) begin
                    since_match = 0;
                    if (open_starts.size() < OPEN_SLOTS)
                        open_starts = {open_starts, pos + 1};
                    else
                        overflow_seen = 1'b1;
                end
                next_pos = pos + 1;
            end

            ovf = overflow_seen;

            if (word.last_byte) begin
                foreach (open_starts[i])
                    found = {found, make_value(1'b1, open_starts[i],
                                               next_pos - open_starts[i])};
                if (found.size() == 0)
                    found = {found, make_value(1'b0, 0, 0)};
                clear_string();
            end

            foreach (found[i]) begin
                found[i].overflow    = ovf;
                found[i].last_result = word.last_byte && (i == found.size() - 1);
                pending_values = {pending_values, found[i]};
            end
        endfunction

        function void compare_field(string name, logic [POS_W-1:0] want,
                                    logic [POS_W-1:0] got, realtime stamp);
            if (got !== want) begin
                $display("%0.1f ns: %s expected %0d, got %0d", stamp, name, want, got);
                error_count++;
            end
        endfunction

        function void check_value_word(result_t got, realtime stamp);
            result_t want;
            if (pending_values.size() == 0) begin
                $display("%0.1f ns: word with none expected, got valid %0d start %0d length %0d",
                         stamp, got.value_valid, got.value_start, got.value_length);
                error_count++;
                return;
            end
            want = pending_values.pop_front();
            compare_field("value_valid", want.value_valid, got.value_valid, stamp);
            compare_field("value_start", want.value_start, got.value_start, stamp);
            compare_field("value_length", want.value_length, got.value_length, stamp);
            compare_field("overflow", want.overflow, got.overflow, stamp);
            compare_field("last_result", want.last_result, got.last_result, stamp);
        endfunction

        function int pending();
            return pending_values.size();
        endfunction

    endclass

endpackage

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// Delimited value extractor testbench
// Drives strings through the byte queue of the extractor under several
// register settings and idle patterns, predicts every value word and checks
// the popped words in order. Covers directed corner cases, random strings
// and a long receiver stall.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import dve_pkg::*;
    import extractor_scoreboard_pkg::*;

    // Even with nine words per byte and the receiver idle most of the time, a run
    // stays far below this limit.
    localparam int CYCLE_LIMIT     = 200_000;
    localparam int DRAIN_CYCLES    = 16;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASE_BYTES     = 40;

    typedef logic [7:0] octets_t [$];

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   push     = 1'b0;
    logic                   full;
    item_t                  item     = '0;
    logic                   empty;
    logic                   pop      = 1'b0;
    result_t                result;
    logic                   wr_en    = 1'b0;
    logic [CFG_INDEX_W-1:0] wr_index = '0;
    logic [CFG_DATA_W-1:0]  wr_data  = '0;

    extractor_scoreboard sb = new();

    // Idle percentages of the two sides; the main process changes them.
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;

    // A request for one long receiver stall, taken up by the pop process.
    bit          hold_req    = 1'b0;
    int          hold_left   = 0;
    longint      cycle_count = 0;

    // Copy of the current settings used to shape the random strings.
    logic [127:0] cur_pattern = '0;
    int           cur_len     = 1;
    logic [7:0]   cur_end     = '0;

    delimited_value_extractor_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .empty    (empty),
        .pop      (pop),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side. A word is taken at an edge where pop is high and empty is
    // low; both are sampled before the edge updates anything. After that the
    // pop for the next edge is chosen, either by the idle percentage or by a
    // pending long stall.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
                sb.check_value_word(result, $realtime);
            if (hold_req && hold_left == 0)
            begin
                hold_left = HOLD_OFF_CYCLES;
                hold_req  = 1'b0;
            end
            if (!rst_n)
                pop <= 1'b0;
            else if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else
                pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Offers one byte and waits until the block takes it. Push is left high
    // on return so that back-to-back words keep it asserted without a dip.
    task automatic send_byte(logic [7:0] data, bit last);
        item_t word;
        word.data_byte = data;
        word.last_byte = last;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= word;
        do
            @(posedge clk);
        while (full);
        sb.accept_byte(word);
    endtask

    task automatic send_text(octets_t text);
        foreach (text[i])
            send_byte(text[i], i == text.size() - 1);
    endtask

    // Lowers push, waits for every predicted word and then lets the back end
    // finish the end of the string before anything else happens.
    task automatic finish_phase();
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg_word(reg_index_t index, logic [CFG_DATA_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= index;
        wr_data  <= data;
        @(posedge clk);
        sb.write_reg(index, data);
    endtask

    // Writes all four registers on consecutive edges; the block is idle here.
    task automatic configure(logic [63:0] low_bytes, logic [63:0] high_bytes,
                             logic [4:0] len_raw, logic [7:0] end_byte);
        write_reg_word(REG_PATTERN_LOW, low_bytes);
        write_reg_word(REG_PATTERN_HIGH, high_bytes);
        write_reg_word(REG_PATTERN_LEN, {59'd0, len_raw});
        write_reg_word(REG_END_CHAR, {56'd0, end_byte});
        wr_en <= 1'b0;
        cur_pattern = {high_bytes, low_bytes};
        cur_end     = end_byte;
        if (len_raw == 0)
            cur_len = 1;
        else if (len_raw > PATTERN_SLOTS)
            cur_len = PATTERN_SLOTS;
        else
            cur_len = int'(len_raw);
    endtask

    function automatic octets_t to_octets(string s);
        octets_t text;
        for (int i = 0; i < s.len(); i++)
            text = {text, s[i]};
        return text;
    endfunction

    // Half of the bytes come from a tiny alphabet so that patterns repeat
    // themselves and overlapping occurrences show up.
    function automatic logic [63:0] random_pattern_half();
        logic [63:0] bytes;
        for (int i = 0; i < 8; i++)
            if ($urandom_range(1))
                bytes[i*8 +: 8] = 8'(8'h61 + $urandom_range(2));
            else
                bytes[i*8 +: 8] = 8'($urandom_range(255));
        return bytes;
    endfunction

    // A string built from pieces: whole patterns, end characters, bytes taken
    // from the pattern, cut-off patterns and plain noise.
    function automatic octets_t random_text();
        octets_t text;
        int      pieces;
        int      kind;
        int      cut;
        pieces = $urandom_range(1, 8);
        repeat (pieces)
        begin
            kind = $urandom_range(99);
            if (kind < 35)
            begin
                for (int i = 0; i < cur_len; i++)
                    text = {text, cur_pattern[i*8 +: 8]};
            end
            else if (kind < 55)
                text = {text, cur_end};
            else if (kind < 80)
            begin
                repeat ($urandom_range(1, 4))
                    text = {text, cur_pattern[$urandom_range(cur_len - 1)*8 +: 8]};
            end
            else if (kind < 90 && cur_len > 1)
            begin
                cut = $urandom_range(1, cur_len - 1);
                for (int i = 0; i < cut; i++)
                    text = {text, cur_pattern[i*8 +: 8]};
            end
            else
                text = {text, 8'($urandom_range(255))};
        end
        return text;
    endfunction

    task automatic run_random_phase(logic [4:0] len_raw, logic [7:0] end_byte);
        int sent;
        sent = 0;
        configure(random_pattern_half(), random_pattern_half(), len_raw, end_byte);
        while (sent < PHASE_BYTES)
        begin
            octets_t text;
            text = random_text();
            send_text(text);
            sent += text.size();
        end
        finish_phase();
    endtask

    initial
    begin
        octets_t text;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Sender idles a little, receiver most of the time.
        tx_idle_pct = 8;
        rx_idle_pct = 69;

        // Directed strings with a two-byte pattern and ';' as end character:
        // a pattern at the very end gives an empty value, an end character
        // right at a value's first byte does not close it, two values close
        // on one end character, and a string with no value gives a bare
        // end marker.
        configure(64'h6261, 64'h0, 5'd2, 8'h3B);
        send_text(to_octets("ab"));
        send_text(to_octets("ab;"));
        send_text(to_octets("ab1ab2;"));
        send_text(to_octets("z"));
        finish_phase();

        // A length of zero acts as one. Every 0xFF opens a value; the zero
        // byte is both the end character and the lowest byte value. The
        // second string opens more values than the block can hold.
        configure(64'hFF, 64'h0, 5'd0, 8'h00);
        text = {8'hFF, 8'hFF, 8'h00};
        send_text(text);
        text.delete();
        repeat (10) text = {text, 8'hFF};
        send_text(text);
        finish_phase();

        run_random_phase(5'd1, 8'($urandom_range(255)));
        run_random_phase(5'd16, 8'h00);

        // Now the receiver is the eager side.
        tx_idle_pct = 69;
        rx_idle_pct = 8;
        run_random_phase(5'd0, 8'hFF);
        run_random_phase(5'($urandom_range(2, 5)), 8'($urandom_range(255)));

        // Neither side idles.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random_phase(5'd31, 8'($urandom_range(255)));
        run_random_phase(5'($urandom_range(1, 16)), 8'($urandom_range(255)));

        // The receiver stops popping for a long stretch while strings full of
        // short values keep coming, so the command queue fills and full
        // holds the sender back.
        configure(64'h5A, 64'h0, 5'd1, 8'h3B);
        hold_req = 1'b1;
        repeat (8)
        begin
            text = random_text();
            send_text(text);
        end
        finish_phase();

        if (sb.error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/dve_pkg.sv
rtl/core/dve_front.sv
rtl/core/dve_cmd_queue.sv
rtl/core/dve_back.sv
rtl/core/delimited_value_extractor_core.sv
verif/extractor_scoreboard_pkg.sv
verif/testbench.sv
